// ===== rtl/core/dpt_pkg.sv =====
// Shared widths, constants and types of the debounced pulse tachometer.
package dpt_pkg;

  localparam int PPR_W   = 16;   // pulses per revolution register
  localparam int DEB_W   = 20;   // debounce lockout register
  localparam int WIN_W   = 16;   // minimum window register
  localparam int STAMP_W = 32;   // input timestamps
  localparam int CNT_W   = 32;   // pulse count
  localparam int RPM_W   = 32;   // unsigned 24.8 speed
  localparam int DATA_W  = 32;   // configuration data
  localparam int ADDR_W  = 4;    // configuration byte address

  // 60000 ms per minute times 256 for the 8 fraction bits.
  localparam int SCALE_W = 24;
  localparam logic [SCALE_W-1:0] RPM_SCALE = 24'd15360000;
  localparam int NUM_W   = CNT_W + SCALE_W;
  localparam int QUO_BITS = RPM_W;

  localparam logic [RPM_W-1:0] RPM_SAT = '1;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // Request queue between front and back.
  localparam int Q_DEPTH = 2;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_PPR      = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_MIN_WIN  = 2'd2;

  // Window decision that the front hands to the back for one speed request.
  typedef struct packed {
    logic             closed;
    logic [CNT_W-1:0] taken;
  } dpt_win_t;

endpackage

// ===== rtl/core/dpt_queue.sv =====
// Short word queue between the front and the back.
module dpt_queue
  import dpt_pkg::*;
#(
  parameter int WIDTH = 65
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam logic [PW-1:0] LAST_SLOT = PW'(Q_DEPTH - 1);
  localparam logic [PW:0]   FULL_CNT  = (PW + 1)'(Q_DEPTH);

  logic [WIDTH-1:0] slots [Q_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/dpt_front.sv =====
// Front: accept words, debounce edges, count pulses and decide speed windows.
module dpt_front
  import dpt_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [STAMP_W-1:0]   edge_time_us,
  input  logic [STAMP_W-1:0]   now_ms,
  input  logic [DEB_W-1:0]     debounce_us,
  input  logic [WIN_W-1:0]     min_window_ms,
  input  logic                 q_full,
  output logic                 push,
  output dpt_win_t             push_win,
  output logic [TIME_BITS-1:0] push_elapsed
);

  localparam int CW = (TIME_BITS > DEB_W) ? TIME_BITS : DEB_W;

  logic [CNT_W-1:0]     pulse_total;
  logic [TIME_BITS-1:0] last_edge_us;
  logic [TIME_BITS-1:0] window_start_ms;

  logic                 accept;
  logic [TIME_BITS-1:0] edge_t;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] edge_gap;
  logic                 edge_ok;
  logic                 win_done;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign edge_t   = TIME_BITS'(edge_time_us);
  assign now_t    = TIME_BITS'(now_ms);
  assign edge_gap = edge_t - last_edge_us;
  assign edge_ok  = CW'(edge_gap) > CW'(debounce_us);

  assign push_elapsed = now_t - window_start_ms;
  assign win_done     = push_elapsed >= TIME_BITS'(min_window_ms);

  assign push            = accept && command;
  assign push_win.closed = win_done;
  assign push_win.taken  = win_done ? pulse_total : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_total     <= '0;
      last_edge_us    <= '0;
      window_start_ms <= '0;
    end else if (accept) begin
      if (!command) begin
        if (edge_ok) begin
          if (pulse_total != CNT_SAT) begin
            pulse_total <= pulse_total + 1'b1;
          end
          last_edge_us <= edge_t;
        end
      end else if (win_done) begin
        window_start_ms <= now_t;
        pulse_total     <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/dpt_back.sv =====
// Back: compute the speed of a closed window and drive the result register.
module dpt_back
  import dpt_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  dpt_win_t             q_win,
  input  logic [TIME_BITS-1:0] q_elapsed,
  output logic                 pop,
  input  logic [PPR_W-1:0]     pulses_per_rev,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RPM_W-1:0]     rpm_q8,
  output logic                 window_closed,
  output logic [CNT_W-1:0]     pulses_in_window
);

  localparam int DW = PPR_W + TIME_BITS;
  localparam int SW = DW + QUO_BITS;
  localparam int CTR_W = $clog2(QUO_BITS);
  localparam logic [CTR_W-1:0] DIV_LAST = CTR_W'(QUO_BITS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_CHK  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic [RPM_W-1:0]     held_rpm;
  logic                 closed;
  logic [CNT_W-1:0]     taken;
  logic [TIME_BITS-1:0] elapsed;
  logic [NUM_W-1:0]     num;
  logic [DW-1:0]        den;
  logic [DW-1:0]        rem;
  logic [QUO_BITS-1:0]  quo;
  logic [CTR_W-1:0]     cnt;

  logic                 load_out;
  logic                 sat;
  logic [DW:0]          trial;
  logic [DW:0]          trial_diff;
  logic                 fits;

  // Quotient of at least 2^32 saturates; this also covers a zero divisor.
  assign sat        = SW'(num) >= {den, {QUO_BITS{1'b0}}};
  assign trial      = {rem, quo[QUO_BITS-1]};
  assign trial_diff = trial - {1'b0, den};
  assign fits       = trial >= {1'b0, den};

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          state_next = (q_win.closed && (q_win.taken != '0)) ? S_MUL : S_DONE;
        end
      end
      S_MUL: state_next = S_CHK;
      S_CHK: state_next = sat ? S_DONE : S_DIV;
      S_DIV: begin
        if (cnt == DIV_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held_rpm  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop && q_win.closed && (q_win.taken == '0)) begin
        held_rpm <= '0;
      end else if ((state == S_CHK) && sat) begin
        held_rpm <= RPM_SAT;
      end else if ((state == S_DIV) && (cnt == DIV_LAST)) begin
        held_rpm <= {quo[QUO_BITS-2:0], fits};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      closed  <= q_win.closed;
      taken   <= q_win.taken;
      elapsed <= q_elapsed;
    end
    if (state == S_MUL) begin
      num <= {{SCALE_W{1'b0}}, taken} * {{CNT_W{1'b0}}, RPM_SCALE};
      den <= DW'(pulses_per_rev) * DW'(elapsed);
    end
    if (state == S_CHK) begin
      rem <= DW'(num[NUM_W-1:QUO_BITS]);
      quo <= num[QUO_BITS-1:0];
      cnt <= '0;
    end
    if (state == S_DIV) begin
      rem <= fits ? trial_diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[QUO_BITS-2:0], fits};
      cnt <= cnt + 1'b1;
    end
    if (load_out) begin
      rpm_q8           <= held_rpm;
      window_closed    <= closed;
      pulses_in_window <= taken;
    end
  end

endmodule

// ===== rtl/core/debounced_pulse_tachometer_core.sv =====
// Debounced pulse tachometer: configuration registers, front, request queue and back.
// An edge word (command 0) never produces a result: the front counts it when its
// wrapping distance from the last counted edge is strictly greater than debounce_us.
// A speed request (command 1) produces exactly one result word. The front decides at
// once whether the window closes, takes and clears the pulse count and hands the
// decision to a two-entry queue, so edges keep flowing while the back works. For a
// closing request that has pulses the back dequeues it, forms the two products,
// checks for saturation, runs the bit-serial restoring divider over the 32 quotient
// bits and loads the output register; when the saturation check already settles the
// speed it skips the divider, and any other request goes from dequeue straight to the
// output register. The back takes a new request only after loading the last result.
// The input stalls only when two requests wait in the queue. Speed is
// pulses*60000*256/(pulses_per_rev*elapsed_ms), truncated, saturated at all ones.
// Timestamps and their differences wrap at TIME_BITS bits. Registers sit at byte
// addresses 0 (pulses_per_rev), 4 (debounce_us) and 8 (min_window_ms) and may only
// be written while the block is idle.
module debounced_pulse_tachometer_core
  import dpt_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [STAMP_W-1:0] edge_time_us,
  input  logic [STAMP_W-1:0] now_ms,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RPM_W-1:0]   rpm_q8,
  output logic               window_closed,
  output logic [CNT_W-1:0]   pulses_in_window,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int QW = $bits(dpt_win_t) + TIME_BITS;

  logic [PPR_W-1:0]     pulses_per_rev;
  logic [DEB_W-1:0]     debounce_us;
  logic [WIN_W-1:0]     min_window_ms;
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;

  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_valid;
  dpt_win_t             push_win;
  logic [TIME_BITS-1:0] push_elapsed;
  logic [QW-1:0]        q_out;
  dpt_win_t             q_win;
  logic [TIME_BITS-1:0] q_elapsed;

  // Register file: write in the access phase, read back combinationally.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_rev <= PPR_W'(20);
      debounce_us    <= DEB_W'(1000);
      min_window_ms  <= WIN_W'(100);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PPR:      pulses_per_rev <= pwdata[PPR_W-1:0];
        REG_DEBOUNCE: debounce_us    <= pwdata[DEB_W-1:0];
        REG_MIN_WIN:  min_window_ms  <= pwdata[WIN_W-1:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PPR:      prdata = DATA_W'(pulses_per_rev);
      REG_DEBOUNCE: prdata = DATA_W'(debounce_us);
      REG_MIN_WIN:  prdata = DATA_W'(min_window_ms);
      default:      prdata = '0;
    endcase
  end

  // Front: debounce and window decision, one word per cycle while the queue is not full.
  dpt_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .edge_time_us  (edge_time_us),
    .now_ms        (now_ms),
    .debounce_us   (debounce_us),
    .min_window_ms (min_window_ms),
    .q_full        (q_full),
    .push          (q_push),
    .push_win      (push_win),
    .push_elapsed  (push_elapsed)
  );

  // Queue of pending speed requests, in arrival order.
  dpt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_win, push_elapsed}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  assign q_win     = q_out[QW-1:TIME_BITS];
  assign q_elapsed = q_out[TIME_BITS-1:0];

  // Back: speed arithmetic, held speed and the result register.
  dpt_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_win            (q_win),
    .q_elapsed        (q_elapsed),
    .pop              (q_pop),
    .pulses_per_rev   (pulses_per_rev),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .rpm_q8           (rpm_q8),
    .window_closed    (window_closed),
    .pulses_in_window (pulses_in_window)
  );

endmodule

// ===== rtl/core/dpt_checker.sv =====
// Port-level checks of the tachometer core and their binding.
module dpt_checker
  import dpt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic [RPM_W-1:0] rpm_q8,
  input logic             window_closed,
  input logic [CNT_W-1:0] pulses_in_window
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rpm_q8) && $stable(window_closed)
      && $stable(pulses_in_window))
    else $error("result word changed while stalled");

  // An open window reports no pulses.
  a_open_no_pulses: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_closed |-> pulses_in_window == '0)
    else $error("pulses reported for an open window");

  // A closed window without pulses reports zero speed.
  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_closed && (pulses_in_window == '0) |-> rpm_q8 == '0)
    else $error("nonzero speed without pulses");

  // No result word right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind debounced_pulse_tachometer_core dpt_checker u_dpt_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .rpm_q8           (rpm_q8),
  .window_closed    (window_closed),
  .pulses_in_window (pulses_in_window)
);

// ===== bench/tach_bench_pkg.sv =====
// Command codes shared by the tachometer bench stimulus and checker.
`timescale 1ns / 100ps
package tach_bench_pkg;

  typedef enum logic {
    CMD_EDGE  = 1'b0,
    CMD_SPEED = 1'b1
  } tach_cmd_e;

endpackage

// ===== bench/dpt_speed_checker.sv =====
// Channel monitor, speed predictor and result comparison for the tachometer core.
`timescale 1ns / 100ps
module dpt_speed_checker
  import dpt_pkg::*;
  import tach_bench_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               command,
  input  logic [STAMP_W-1:0] edge_time_us,
  input  logic [STAMP_W-1:0] now_ms,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [RPM_W-1:0]   rpm_q8,
  input  logic               window_closed,
  input  logic [CNT_W-1:0]   pulses_in_window,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [DATA_W-1:0]  prdata,
  input  logic               pready,
  output int unsigned        errors,
  output int unsigned        pending,
  output int unsigned        results_seen,
  output int unsigned        closed_seen
);

  localparam logic [PPR_W-1:0] PPR_RESET = 16'd20;
  localparam logic [DEB_W-1:0] DEB_RESET = 20'd1000;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd100;
  // ms per minute times 2^8 for the fraction bits
  localparam logic [63:0] MINUTE_Q8 = 64'd60000 * 64'd256;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             closed;
    logic [CNT_W-1:0] taken;
  } speed_word_t;

  logic [PPR_W-1:0]   cfg_ppr;
  logic [DEB_W-1:0]   cfg_debounce;
  logic [WIN_W-1:0]   cfg_min_win;
  logic [CNT_W-1:0]   pulse_count;
  logic [STAMP_W-1:0] last_edge;
  logic [STAMP_W-1:0] window_start;
  logic [RPM_W-1:0]   speed_held;
  speed_word_t        speed_words_due [$];

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    closed_seen = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [RPM_W-1:0] q8_speed(input logic [CNT_W-1:0] pulses,
                                                input logic [PPR_W-1:0] ppr,
                                                input logic [STAMP_W-1:0] elapsed);
    logic [63:0] num;
    logic [63:0] quo;
    if (pulses == '0) return '0;
    if (ppr == '0 || elapsed == '0) return RPM_SAT;
    num = {32'b0, pulses} * MINUTE_Q8;
    quo = (num / {48'b0, ppr}) / {32'b0, elapsed};
    return (quo > {32'b0, RPM_SAT}) ? RPM_SAT : quo[RPM_W-1:0];
  endfunction

  // Count the edge only when strictly past the lockout, wrapping distance.
  function automatic void count_edge(input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] stamp_gap;
    stamp_gap = stamp - last_edge;
    if (stamp_gap > cfg_debounce) begin
      if (pulse_count != CNT_SAT) pulse_count = pulse_count + 1'b1;
      last_edge = stamp;
    end
  endfunction

  function automatic speed_word_t close_window(input logic [STAMP_W-1:0] now);
    speed_word_t w;
    logic [STAMP_W-1:0] elapsed;
    elapsed = now - window_start;
    w.closed = 1'b0;
    w.taken = '0;
    if (elapsed >= cfg_min_win) begin
      window_start = now;
      w.closed = 1'b1;
      w.taken = pulse_count;
      pulse_count = '0;
      speed_held = q8_speed(w.taken, cfg_ppr, elapsed);
    end
    w.rpm = speed_held;
    return w;
  endfunction

  always @(posedge clk) begin
    speed_word_t want;
    logic [DATA_W-1:0] reg_want;
    if (rst) begin
      cfg_ppr = PPR_RESET;
      cfg_debounce = DEB_RESET;
      cfg_min_win = WIN_RESET;
      pulse_count = '0;
      last_edge = '0;
      window_start = '0;
      speed_held = '0;
      speed_words_due.delete();
    end else begin
      if (psel && penable && pready) begin
        reg_want = '0;
        case (paddr[3:2])
          REG_PPR: begin
            if (pwrite) cfg_ppr = pwdata[PPR_W-1:0];
            reg_want[PPR_W-1:0] = cfg_ppr;
          end
          REG_DEBOUNCE: begin
            if (pwrite) cfg_debounce = pwdata[DEB_W-1:0];
            reg_want[DEB_W-1:0] = cfg_debounce;
          end
          REG_MIN_WIN: begin
            if (pwrite) cfg_min_win = pwdata[WIN_W-1:0];
            reg_want[WIN_W-1:0] = cfg_min_win;
          end
          default: ;
        endcase
        if (!pwrite && prdata !== reg_want) report_mismatch("prdata", prdata, reg_want);
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_EDGE) count_edge(edge_time_us);
        else speed_words_due.push_back(close_window(now_ms));
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (speed_words_due.size() == 0) begin
          report_mismatch("result word with no request waiting", rpm_q8, '0);
        end else begin
          want = speed_words_due.pop_front();
          if (rpm_q8 !== want.rpm) report_mismatch("rpm_q8", rpm_q8, want.rpm);
          if (window_closed !== want.closed)
            report_mismatch("window_closed", {31'b0, window_closed}, {31'b0, want.closed});
          if (pulses_in_window !== want.taken)
            report_mismatch("pulses_in_window", pulses_in_window, want.taken);
          if (want.closed) closed_seen++;
        end
      end
    end
    pending = speed_words_due.size();
  end

endmodule

// ===== bench/tb.sv =====
// Stimulus, register setup and verdict for the debounced pulse tachometer core.
`timescale 1ns / 100ps
module tb;
  import dpt_pkg::*;
  import tach_bench_pkg::*;

  localparam int unsigned IDLE_PCT      = 36;      // idle chance per word, each side
  localparam int unsigned HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 64;      // settle time after the last result word
  localparam int unsigned PHASE_WORDS   = 175;     // mixed words per register setting
  localparam int unsigned BURST_EDGES   = 320;     // enough pulses to saturate the speed
  localparam int unsigned LIMIT_CYCLES  = 600000;
  localparam int          N_SETTINGS    = 6;
  localparam int          SAT_SETTING   = 0;
  localparam int          QUIET_SETTING = 3;
  localparam int          HOLD_SETTING  = 4;

  typedef struct {
    logic [DATA_W-1:0] ppr;
    logic [DATA_W-1:0] deb;
    logic [DATA_W-1:0] win;
  } setting_t;

  // DUT inputs start at known values
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               command = 1'b0;
  logic [STAMP_W-1:0] edge_time_us = '0;
  logic [STAMP_W-1:0] now_ms = '0;
  logic               out_stall = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;

  logic               in_stall;
  logic               out_valid;
  logic [RPM_W-1:0]   rpm_q8;
  logic               window_closed;
  logic [CNT_W-1:0]   pulses_in_window;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int unsigned errors;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned closed_seen;

  // knobs shared between the stimulus process and the receiver process
  logic        src_quiet = 1'b0;
  logic        sink_quiet = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned edges_sent = 0;
  int unsigned requests_sent = 0;

  // running timebases for well-formed sequences and the current register values
  logic [STAMP_W-1:0] us_now;
  logic [STAMP_W-1:0] ms_now;
  int unsigned        cur_deb = 1000;
  int unsigned        cur_win = 100;
  setting_t           plan [N_SETTINGS];

  debounced_pulse_tachometer_core i_dut (.*);

  dpt_speed_checker i_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bound the run: a hung handshake or a missing result word ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d result words outstanding",
               cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, a quiet mode, and one long hold-off counted here.
  initial begin : sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (sink_quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Offer one word and hold it until accepted. Enter and leave at a rising edge;
  // valid stays high into the next word unless an idle gap drops it.
  task automatic send_word(input tach_cmd_e cmd, input logic [STAMP_W-1:0] t_us,
                           input logic [STAMP_W-1:0] t_ms);
    if (!src_quiet)
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    command <= cmd;
    edge_time_us <= t_us;
    now_ms <= t_ms;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_EDGE) edges_sent++;
    else requests_sent++;
  endtask

  // Stop offering and wait until every predicted result word has come back.
  // Sample the count at the falling edge so the checker has updated it.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup phase, access phase until pready, then back to idle.
  task automatic reg_access(input logic [1:0] idx, input logic wr,
                            input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Edge spacing around the lockout, hitting the boundary on both sides.
  function automatic logic [STAMP_W-1:0] edge_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return cur_deb;
    if (r < 20) return cur_deb + 1;
    return $urandom_range(0, 2 * cur_deb + 2);
  endfunction

  // Request spacing around the minimum window, hitting the boundary too.
  function automatic logic [STAMP_W-1:0] window_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return cur_win - 1;
    if (r < 20) return cur_win;
    return $urandom_range(0, 2 * cur_win + 1);
  endfunction

  // Mostly well-formed windows (edges then a request), plus noise words,
  // timebase jumps across the wrap and full pauses.
  task automatic run_mixed(input int unsigned n_words);
    int unsigned base;
    int unsigned r;
    int unsigned k;
    base = edges_sent + requests_sent;
    while (edges_sent + requests_sent - base < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        k = $urandom_range(0, 10);
        repeat (k) begin
          us_now += edge_gap();
          send_word(CMD_EDGE, us_now, $urandom());
        end
        ms_now += window_gap();
        send_word(CMD_SPEED, $urandom(), ms_now);
      end else if (r < 91) begin
        send_word(tach_cmd_e'($urandom_range(0, 1)), $urandom(), $urandom());
      end else if (r < 97) begin
        if ($urandom_range(0, 1)) begin
          us_now = 32'hFFFF_FFFF - $urandom_range(0, 3 * cur_deb + 3);
          ms_now = 32'hFFFF_FFFF - $urandom_range(0, 3 * cur_win + 3);
        end else begin
          us_now = $urandom();
          ms_now = $urandom();
        end
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    plan[0] = '{32'd1, 32'd0, 32'd1};                // fastest windows, saturating speed
    plan[1] = '{32'd65535, 32'hF_FFFF, 32'd65535};   // all registers at their top
    plan[2] = '{32'd0, 32'd0, 32'd0};                // zero denominators
    plan[3] = '{32'd7, 32'd250, 32'd10};
    plan[4] = '{($urandom() & 32'hFFFF_0000) | $urandom_range(1, 65535),
                ($urandom() & 32'hFFF0_0000) | $urandom_range(0, 1000000),
                ($urandom() & 32'hFFFF_0000) | $urandom_range(1, 65535)};
    plan[5] = '{32'd20, 32'd1000, 32'd100};          // back to the reset values

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset values.
    send_word(CMD_SPEED, 32'hFFFF_FFFF, 32'd0);        // window not closed, speed zero
    send_word(CMD_EDGE, 32'd0, 32'hFFFF_FFFF);         // same time as the last edge
    send_word(CMD_EDGE, 32'd1000, 32'd0);              // exactly at the lockout
    send_word(CMD_EDGE, 32'd1001, 32'd0);              // just past it
    send_word(CMD_EDGE, 32'hFFFF_FFFF, 32'd0);
    send_word(CMD_EDGE, 32'd1000, 32'd0);              // distance wraps to 1001
    send_word(CMD_SPEED, 32'd0, 32'd99);               // one ms short of the window
    send_word(CMD_SPEED, 32'd0, 32'd100);              // closes with three pulses
    send_word(CMD_SPEED, 32'd0, 32'd100);              // zero elapsed, speed held
    send_word(CMD_SPEED, 32'd0, 32'hFFFF_FFFF);        // closes with no pulses
    send_word(CMD_EDGE, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_word(CMD_EDGE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_word(CMD_SPEED, 32'hA5A5_A5A5, 32'd99);       // elapsed wraps to 100
    send_word(CMD_EDGE, 32'h7FFF_FFFF, 32'd0);
    send_word(CMD_SPEED, 32'h5A5A_5A5A, 32'd199);      // one pulse over 100 ms
    send_word(CMD_SPEED, 32'd0, 32'h8000_0000);
    us_now = 32'h7FFF_FFFF;
    ms_now = 32'h8000_0000;
    run_mixed(PHASE_WORDS);

    for (int s = 0; s < N_SETTINGS; s++) begin
      // Registers change only with nothing in flight; read each one back.
      drain_results();
      reg_access(REG_PPR, 1'b1, plan[s].ppr);
      reg_access(REG_DEBOUNCE, 1'b1, plan[s].deb);
      reg_access(REG_MIN_WIN, 1'b1, plan[s].win);
      reg_access(REG_PPR, 1'b0, '0);
      reg_access(REG_DEBOUNCE, 1'b0, '0);
      reg_access(REG_MIN_WIN, 1'b0, '0);
      cur_deb = plan[s].deb[DEB_W-1:0];
      cur_win = plan[s].win[WIN_W-1:0];
      src_quiet = (s == QUIET_SETTING);
      sink_quiet = (s == QUIET_SETTING);
      // Stall the receiver while words keep coming, so the queue fills.
      if (s == HOLD_SETTING) hold_req = 1'b1;
      if (s == SAT_SETTING) begin
        // Pile hundreds of pulses into a one ms window to drive the speed to all ones.
        send_word(CMD_SPEED, $urandom(), ms_now);
        repeat (BURST_EDGES) begin
          us_now += $urandom_range(1, 40);
          send_word(CMD_EDGE, us_now, $urandom());
        end
        ms_now += 1;
        send_word(CMD_SPEED, $urandom(), ms_now);
      end
      run_mixed(PHASE_WORDS);
    end
    src_quiet = 1'b0;
    sink_quiet = 1'b0;
    drain_results();

    $display("Covered %0d edge words and %0d speed requests over %0d register settings",
             edges_sent, requests_sent, N_SETTINGS + 1);
    $display("Checked %0d result words, %0d of them closing a window",
             results_seen, closed_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== debounced_pulse_tachometer_core.f =====
rtl/core/dpt_pkg.sv
rtl/core/dpt_queue.sv
rtl/core/dpt_front.sv
rtl/core/dpt_back.sv
rtl/core/debounced_pulse_tachometer_core.sv
rtl/core/dpt_checker.sv
bench/tach_bench_pkg.sv
bench/dpt_speed_checker.sv
bench/tb.sv
